// File: rtl/complex_arithmetic_unit_defines.svh
// Assertion macros shared by the complex arithmetic unit.
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// Checks that a consequent holds whenever its antecedent does, outside reset.
`define CAU_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks a plain condition at every clock edge outside reset.
`define CAU_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

// File: rtl/cau_pkg.sv
`timescale 1ns / 1ps
package cau_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int SQ_W       = 2 * DATA_WIDTH;
  localparam int LIN_W      = 2 * DATA_WIDTH + 2;
  localparam int REM_W      = 3 * DATA_WIDTH + 2;
  localparam int QW         = DATA_WIDTH + 1;

  localparam logic [2:0] ACT_ADD  = 3'd0;
  localparam logic [2:0] ACT_MUL  = 3'd1;
  localparam logic [2:0] ACT_CONJ = 3'd2;
  localparam logic [2:0] ACT_MOD  = 3'd3;
  localparam logic [2:0] ACT_INV  = 3'd4;

  typedef struct packed {
    logic [2:0]                   action;
    logic signed [DATA_WIDTH-1:0] a_re;
    logic signed [DATA_WIDTH-1:0] a_im;
    logic signed [DATA_WIDTH-1:0] b_re;
    logic signed [DATA_WIDTH-1:0] b_im;
  } req_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] res_re;
    logic signed [DATA_WIDTH-1:0] res_im;
    logic                         div_by_zero;
    logic                         saturated;
  } rsp_item_t;

  // State of one item between the front end and the output stage.
  typedef struct packed {
    logic [2:0]              action;
    logic signed [LIN_W-1:0] lin_re;
    logic signed [LIN_W-1:0] lin_im;
    logic [SQ_W-1:0]         den;
    logic [DATA_WIDTH-1:0]   root;
    logic [SQ_W-1:0]         sq_rem;
    logic [REM_W-1:0]        rem_re;
    logic [REM_W-1:0]        rem_im;
    logic [QW-1:0]           q_re;
    logic [QW-1:0]           q_im;
    logic                    neg_re;
    logic                    neg_im;
    logic                    ovf_re;
    logic                    ovf_im;
    logic                    dz;
  } work_t;

endpackage

// File: rtl/cau_front.sv
`timescale 1ns / 1ps
module cau_front #(
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               in_valid,
  input  cau_pkg::req_item_t in_item,
  output logic               out_valid,
  output cau_pkg::work_t     out_work
);

  localparam int W  = cau_pkg::DATA_WIDTH;
  localparam int LW = cau_pkg::LIN_W;

  typedef struct packed {
    logic [2:0]             action;
    logic signed [W-1:0]    a_re;
    logic signed [W-1:0]    a_im;
    logic signed [2*W-1:0]  p_rr;
    logic signed [2*W-1:0]  p_ii;
    logic signed [2*W-1:0]  p_ri;
    logic signed [2*W-1:0]  p_ir;
    logic [2*W-1:0]         s_rr;
    logic [2*W-1:0]         s_ii;
    logic signed [W:0]      sum_re;
    logic signed [W:0]      sum_im;
  } prod_t;

  prod_t               prod;
  prod_t               prod_next;
  logic                prod_valid;
  cau_pkg::work_t      work_next;
  logic signed [LW-1:0] half;
  logic signed [LW-1:0] mul_re;
  logic signed [LW-1:0] mul_im;
  logic [W-1:0]        mag_re;
  logic [W-1:0]        mag_im;

  assign half = LW'(1) <<< (FRAC_BITS - 1);

  always_comb begin
    prod_next.action = in_item.action;
    prod_next.a_re   = in_item.a_re;
    prod_next.a_im   = in_item.a_im;
    prod_next.p_rr   = in_item.a_re * in_item.b_re;
    prod_next.p_ii   = in_item.a_im * in_item.b_im;
    prod_next.p_ri   = in_item.a_re * in_item.b_im;
    prod_next.p_ir   = in_item.b_re * in_item.a_im;
    prod_next.s_rr   = (2*W)'(in_item.a_re * in_item.a_re);
    prod_next.s_ii   = (2*W)'(in_item.a_im * in_item.a_im);
    prod_next.sum_re = (W+1)'(in_item.a_re) + (W+1)'(in_item.b_re);
    prod_next.sum_im = (W+1)'(in_item.a_im) + (W+1)'(in_item.b_im);
  end

  always_comb begin
    mul_re = (LW'(prod.p_rr) - LW'(prod.p_ii) + half) >>> FRAC_BITS;
    mul_im = (LW'(prod.p_ri) + LW'(prod.p_ir) + half) >>> FRAC_BITS;
    mag_re = prod.a_re[W-1] ? W'(-prod.a_re) : W'(prod.a_re);
    mag_im = prod.a_im[W-1] ? W'(-prod.a_im) : W'(prod.a_im);

    work_next        = '0;
    work_next.action = prod.action;
    case (prod.action)
      cau_pkg::ACT_ADD: begin
        work_next.lin_re = LW'(prod.sum_re);
        work_next.lin_im = LW'(prod.sum_im);
      end
      cau_pkg::ACT_MUL: begin
        work_next.lin_re = mul_re;
        work_next.lin_im = mul_im;
      end
      cau_pkg::ACT_CONJ: begin
        work_next.lin_re = LW'(prod.a_re);
        work_next.lin_im = -LW'(prod.a_im);
      end
      default: begin
        work_next.lin_re = '0;
        work_next.lin_im = '0;
      end
    endcase
    work_next.den    = prod.s_rr + prod.s_ii;
    work_next.sq_rem = prod.s_rr + prod.s_ii;
    work_next.dz     = ((prod.s_rr + prod.s_ii) == '0);
    work_next.rem_re = cau_pkg::REM_W'(mag_re) << (2 * FRAC_BITS);
    work_next.rem_im = cau_pkg::REM_W'(mag_im) << (2 * FRAC_BITS);
    work_next.neg_re = prod.a_re[W-1];
    // The imaginary numerator is the negated input part.
    work_next.neg_im = !prod.a_im[W-1] && (prod.a_im != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else if (advance) begin
      prod_valid <= in_valid;
      out_valid  <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      prod     <= prod_next;
      out_work <= work_next;
    end
  end

endmodule

// File: rtl/cau_iter.sv
`timescale 1ns / 1ps
module cau_iter #(
  parameter int BIT = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           advance,
  input  logic           in_valid,
  input  cau_pkg::work_t in_work,
  output logic           out_valid,
  output cau_pkg::work_t out_work
);

  localparam int W  = cau_pkg::DATA_WIDTH;
  localparam int RW = cau_pkg::REM_W;
  localparam int SW = cau_pkg::SQ_W;

  cau_pkg::work_t  work_next;
  logic [RW-1:0]   div_trial;

  assign div_trial = RW'(in_work.den) << BIT;

  generate
    if (BIT == W + 1) begin : g_ovf
      // Top step only detects a quotient too large for the result range.
      always_comb begin
        work_next        = in_work;
        work_next.ovf_re = (in_work.rem_re >= div_trial);
        work_next.ovf_im = (in_work.rem_im >= div_trial);
      end
    end else begin : g_step
      logic [SW+1:0] sq_trial;
      always_comb begin
        work_next = in_work;
        if (in_work.rem_re >= div_trial) begin
          work_next.rem_re   = in_work.rem_re - div_trial;
          work_next.q_re[BIT] = 1'b1;
        end
        if (in_work.rem_im >= div_trial) begin
          work_next.rem_im   = in_work.rem_im - div_trial;
          work_next.q_im[BIT] = 1'b1;
        end
        sq_trial = '0;
        if (BIT < W) begin
          sq_trial = ((SW+2)'(in_work.root) << (BIT + 1)) + ((SW+2)'(1) << (2 * BIT));
          if ((SW+2)'(in_work.sq_rem) >= sq_trial) begin
            work_next.sq_rem = SW'((SW+2)'(in_work.sq_rem) - sq_trial);
            work_next.root   = in_work.root | (W'(1) << BIT);
          end
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_work <= work_next;
    end
  end

endmodule

// File: rtl/cau_back.sv
`timescale 1ns / 1ps
module cau_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               in_valid,
  input  cau_pkg::work_t     in_work,
  output logic               out_valid,
  output cau_pkg::rsp_item_t out_item
);

  localparam int W  = cau_pkg::DATA_WIDTH;
  localparam int LW = cau_pkg::LIN_W;
  localparam int QW = cau_pkg::QW;
  localparam int RW = cau_pkg::REM_W;

  localparam logic signed [LW-1:0] LinMax = LW'((64'd1 << (W - 1)) - 64'd1);
  localparam logic signed [LW-1:0] LinMin = -LinMax - LW'(1);
  localparam logic [QW:0]          QMax   = (QW+1)'((64'd1 << (W - 1)) - 64'd1);

  cau_pkg::rsp_item_t item_next;
  logic               sat_re;
  logic               sat_im;
  logic [W:0]         root_r;
  logic [QW:0]        qr_re;
  logic [QW:0]        qr_im;

  function automatic logic [W-1:0] clip_lin(input logic signed [LW-1:0] v,
                                            output logic sat);
    sat = 1'b0;
    if (v > LinMax) begin
      sat = 1'b1;
      return W'(LinMax);
    end
    if (v < LinMin) begin
      sat = 1'b1;
      return W'(LinMin);
    end
    return W'(v);
  endfunction

  function automatic logic [W-1:0] clip_quo(input logic [QW:0] q, input logic neg,
                                            input logic ovf, output logic sat);
    sat = 1'b0;
    if (neg) begin
      if (ovf || (q > QMax + (QW+1)'(1))) begin
        sat = 1'b1;
        return W'(LinMin);
      end
      return W'(-q);
    end
    if (ovf || (q > QMax)) begin
      sat = 1'b1;
      return W'(LinMax);
    end
    return W'(q);
  endfunction

  always_comb begin
    qr_re = (QW+1)'(in_work.q_re) +
            (QW+1)'(((RW+1)'(in_work.rem_re) << 1) >= (RW+1)'(in_work.den));
    qr_im = (QW+1)'(in_work.q_im) +
            (QW+1)'(((RW+1)'(in_work.rem_im) << 1) >= (RW+1)'(in_work.den));
    root_r = (W+1)'(in_work.root) +
             (W+1)'(in_work.sq_rem > cau_pkg::SQ_W'(in_work.root));
    item_next = '0;
    sat_re    = 1'b0;
    sat_im    = 1'b0;
    case (in_work.action)
      cau_pkg::ACT_ADD, cau_pkg::ACT_MUL, cau_pkg::ACT_CONJ: begin
        item_next.res_re = clip_lin(in_work.lin_re, sat_re);
        item_next.res_im = clip_lin(in_work.lin_im, sat_im);
      end
      cau_pkg::ACT_MOD: begin
        if (root_r > (W+1)'(LinMax)) begin
          item_next.res_re = W'(LinMax);
          sat_re           = 1'b1;
        end else begin
          item_next.res_re = W'(root_r);
        end
      end
      cau_pkg::ACT_INV: begin
        if (in_work.dz) begin
          item_next.div_by_zero = 1'b1;
        end else begin
          item_next.res_re = clip_quo(qr_re, in_work.neg_re, in_work.ovf_re, sat_re);
          item_next.res_im = clip_quo(qr_im, in_work.neg_im, in_work.ovf_im, sat_im);
        end
      end
      default: begin
        item_next = '0;
      end
    endcase
    item_next.saturated = sat_re || sat_im;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= item_next;
    end
  end

endmodule

// File: rtl/complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// Complex arithmetic unit: add, multiply, conjugate, modulus and inverse on
// signed fixed-point complex operands (Q8.8 in 16 bits by default).
// The request channel (req_valid, req_stall, req_item) takes one transaction
// per cycle while not stalled; a transaction is accepted at a clock edge with
// valid high and stall low. The response channel (rsp_valid, rsp_stall,
// rsp_item) returns exactly one result per request, in order.
// The front end registers the products and sums, then the work item for the
// shared square-root and restoring-division pipeline that follows (at most
// one quotient bit and one root bit per stage); an output register does the
// rounding and saturation. Every operation walks the same pipeline, so
// results never reorder.
// Throughput is one transaction per cycle while the receiver keeps up.
// When the receiver stalls a valid result, the whole pipeline freezes and
// req_stall rises in the same cycle; nothing is dropped or repeated.
// Reset (synchronous, active high) clears all valid bits; the pipeline is
// empty and ready once reset is released.
`include "complex_arithmetic_unit_defines.svh"
module complex_arithmetic_unit #(
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  cau_pkg::req_item_t req_item,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output cau_pkg::rsp_item_t rsp_item
);

  localparam int W     = cau_pkg::DATA_WIDTH;
  localparam int NSTEP = W + 2;

  // The pipeline moves as one unit unless a result sits stalled at the output.
  logic           advance;
  logic           stage_valid [0:NSTEP];
  cau_pkg::work_t stage_work  [0:NSTEP];

  assign advance   = !(rsp_valid && rsp_stall);
  assign req_stall = !advance;

  cau_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (req_valid),
    .in_item  (req_item),
    .out_valid(stage_valid[0]),
    .out_work (stage_work[0])
  );

  // Stage k resolves quotient bit W+1-k (the top one only flags overflow)
  // and, below bit W, the matching square-root bit.
  for (genvar k = 0; k < NSTEP; k++) begin : g_iter
    cau_iter #(
      .BIT(W + 1 - k)
    ) u_iter (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .in_valid (stage_valid[k]),
      .in_work  (stage_work[k]),
      .out_valid(stage_valid[k+1]),
      .out_work (stage_work[k+1])
    );
  end

  cau_back u_back (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (stage_valid[NSTEP]),
    .in_work  (stage_work[NSTEP]),
    .out_valid(rsp_valid),
    .out_item (rsp_item)
  );

  `CAU_ASSERT_IMPLY(a_dz_zero, rsp_valid && rsp_item.div_by_zero,
    rsp_item.res_re == '0 && rsp_item.res_im == '0 && !rsp_item.saturated,
    "division by zero must return a zero, unsaturated result")
  `CAU_ASSERT_IMPLY(a_hold_stalls_req, rsp_valid && rsp_stall, req_stall,
    "a stalled result must hold the request side")
  `CAU_ASSERT_IMPLY(a_stall_cause, req_stall, rsp_valid && rsp_stall,
    "request stall without a stalled result")

endmodule

// File: tb/sv/complex_arithmetic_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the complex arithmetic unit.
// A directed table covers operand extremes, every action, the unused
// selectors, saturation cases and the inverse of zero. Random transactions
// follow, weighted toward the five real actions. Every accepted request is
// passed through a local golden computation and its result is queued; every
// accepted response is compared against the oldest queued result.
module complex_arithmetic_unit_tb;

  localparam int DW = cau_pkg::DATA_WIDTH;
  localparam int FRAC = 8;
  localparam int N_RANDOM = 1300;
  localparam int LAT = cau_pkg::DATA_WIDTH + 5;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  cau_pkg::req_item_t req_item;
  logic rsp_valid;
  logic rsp_stall;
  cau_pkg::rsp_item_t rsp_item;

  complex_arithmetic_unit #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item)
  );

  // One directed row: the request, plus an optional hand-written result.
  typedef struct {
    cau_pkg::req_item_t req;
    bit                 has_known;
    cau_pkg::rsp_item_t known;
  } vector_row_t;

  cau_pkg::rsp_item_t pending_results[$];
  vector_row_t vectors[$];
  int mismatches = 0;
  int sent = 0;
  int received = 0;
  int cycle_count = 0;
  bit quiet_tail = 0;
  bit stimulus_done = 0;
  int rsp_idle_left = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Clip a wide value into the signed result range, raising the flag.
  function automatic logic signed [DW-1:0] clip_value(
      input longint v, inout bit flag);
    longint hi;
    hi = (64'sd1 <<< (DW - 1)) - 1;
    if (v > hi) begin
      flag = 1;
      return DW'(hi);
    end
    if (v < -hi - 1) begin
      flag = 1;
      return DW'(-hi - 1);
    end
    return DW'(v);
  endfunction

  // Integer square root rounded to nearest.
  function automatic longint rounded_root(input longint s);
    longint r;
    r = 0;
    while ((r + 1) * (r + 1) <= s) r = r + 1;
    // Round up when s - r*r exceeds r, i.e. s is past (r+0.5)^2.
    if (s - r * r > r) r = r + 1;
    return r;
  endfunction

  // (num << 2*FRAC) / den with ties away from zero.
  function automatic longint scaled_quotient(input longint num, input longint den);
    longint mag;
    longint q;
    longint rem;
    mag = (num < 0) ? -num : num;
    mag = mag <<< (2 * FRAC);
    q = mag / den;
    rem = mag % den;
    if (rem >= den - rem) q = q + 1;
    return (num < 0) ? -q : q;
  endfunction

  function automatic cau_pkg::rsp_item_t complex_result(input cau_pkg::req_item_t r);
    cau_pkg::rsp_item_t o;
    longint ar, ai, br, bi, mod2, half, m;
    bit sat;
    ar = longint'(r.a_re);
    ai = longint'(r.a_im);
    br = longint'(r.b_re);
    bi = longint'(r.b_im);
    sat = 0;
    half = 64'sd1 <<< (FRAC - 1);
    mod2 = ar * ar + ai * ai;
    o = '0;
    case (r.action)
      cau_pkg::ACT_ADD: begin
        o.res_re = clip_value(ar + br, sat);
        o.res_im = clip_value(ai + bi, sat);
      end
      cau_pkg::ACT_MUL: begin
        o.res_re = clip_value((ar * br - ai * bi + half) >>> FRAC, sat);
        o.res_im = clip_value((ar * bi + br * ai + half) >>> FRAC, sat);
      end
      cau_pkg::ACT_CONJ: begin
        o.res_re = r.a_re;
        o.res_im = clip_value(-ai, sat);
      end
      cau_pkg::ACT_MOD: begin
        m = rounded_root(mod2);
        o.res_re = clip_value(m, sat);
      end
      cau_pkg::ACT_INV: begin
        if (mod2 == 0) begin
          o.div_by_zero = 1;
        end else begin
          o.res_re = clip_value(scaled_quotient(ar, mod2), sat);
          o.res_im = clip_value(scaled_quotient(-ai, mod2), sat);
        end
      end
      default: ;
    endcase
    o.saturated = sat;
    return o;
  endfunction

  function automatic cau_pkg::req_item_t make_req(input logic [2:0] act, input int ar,
      input int ai, input int br, input int bi);
    cau_pkg::req_item_t r;
    r.action = act;
    r.a_re = DW'(ar);
    r.a_im = DW'(ai);
    r.b_re = DW'(br);
    r.b_im = DW'(bi);
    return r;
  endfunction

  task automatic add_row(input cau_pkg::req_item_t r, input bit has_known,
      input cau_pkg::rsp_item_t known);
    vector_row_t v;
    v.req = r;
    v.has_known = has_known;
    v.known = known;
    vectors.push_back(v);
  endtask

  function automatic cau_pkg::rsp_item_t make_rsp(input int re, input int im,
      input bit dz, input bit sat);
    cau_pkg::rsp_item_t o;
    o.res_re = DW'(re);
    o.res_im = DW'(im);
    o.div_by_zero = dz;
    o.saturated = sat;
    return o;
  endfunction

  // Operand generator: mostly full-range random values, with small, moderate and extreme values mixed in.
  function automatic int pick_operand();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32767 : -32768;
      1: return $signed(16'($urandom_range(0, 7))) - 3;
      2: return $signed(16'($urandom_range(0, 2047))) - 1024;
      default: return $signed(16'($urandom));
    endcase
  endfunction

  function automatic cau_pkg::req_item_t random_req();
    logic [2:0] act;
    act = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                       : 3'($urandom_range(0, 4));
    return make_req(act, pick_operand(), pick_operand(), pick_operand(),
                    pick_operand());
  endfunction

  // Present one transaction and hold it until it is accepted. Valid drops
  // only when an idle burst follows, so back-to-back transactions keep it high.
  task automatic send_req(input cau_pkg::req_item_t r);
    int gap;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      req_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1;
    req_item <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_results.push_back(complex_result(r));
    sent++;
  endtask

  // Response side: random stall bursts, checked at each accepted edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        received++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected response re=%0d im=%0d", rsp_item.res_re,
                     rsp_item.res_im);
        end else begin
          cau_pkg::rsp_item_t want;
          want = pending_results.pop_front();
          if (want !== rsp_item) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch #%0d: expected re=%0d im=%0d dz=%0b sat=%0b,",
                        " got re=%0d im=%0d dz=%0b sat=%0b"},
                       received, want.res_re, want.res_im, want.div_by_zero,
                       want.saturated, rsp_item.res_re, rsp_item.res_im,
                       rsp_item.div_by_zero, rsp_item.saturated);
          end
        end
      end
      if (rsp_idle_left > 0) begin
        rsp_idle_left <= rsp_idle_left - 1;
        rsp_stall <= 1;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        rsp_idle_left <= $urandom_range(1, 16) - 1;
        rsp_stall <= 1;
      end else begin
        rsp_stall <= 0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("complex_arithmetic_unit_tb failed");
      $finish;
    end
  end

  initial begin
    cau_pkg::rsp_item_t none;
    none = '0;
    rst = 1;
    req_valid = 0;
    req_item = '0;
    rsp_stall = 0;

    // Directed rows; obvious results are written out, the rest predicted.
    add_row(make_req(cau_pkg::ACT_ADD, 0, 0, 0, 0), 1, make_rsp(0, 0, 0, 0));
    add_row(make_req(cau_pkg::ACT_ADD, 32767, 32767, 1, 1), 1,
            make_rsp(32767, 32767, 0, 1));
    add_row(make_req(cau_pkg::ACT_ADD, -32768, -32768, -1, -1), 1,
            make_rsp(-32768, -32768, 0, 1));
    add_row(make_req(cau_pkg::ACT_ADD, 100, -200, 300, 50), 1,
            make_rsp(400, -150, 0, 0));
    add_row(make_req(cau_pkg::ACT_MUL, 256, 0, 256, 0), 1, make_rsp(256, 0, 0, 0));
    add_row(make_req(cau_pkg::ACT_MUL, 0, 256, 0, 256), 1, make_rsp(-256, 0, 0, 0));
    add_row(make_req(cau_pkg::ACT_MUL, 32767, 32767, 32767, 32767), 0, none);
    add_row(make_req(cau_pkg::ACT_MUL, -32768, -32768, -32768, 32767), 0, none);
    add_row(make_req(cau_pkg::ACT_MUL, 1, 0, 128, 0), 0, none);
    add_row(make_req(cau_pkg::ACT_MUL, -1, 0, 128, 0), 0, none);
    add_row(make_req(cau_pkg::ACT_CONJ, 1234, -5678, 0, 0), 1,
            make_rsp(1234, 5678, 0, 0));
    add_row(make_req(cau_pkg::ACT_CONJ, -32768, -32768, 0, 0), 1,
            make_rsp(-32768, 32767, 0, 1));
    add_row(make_req(cau_pkg::ACT_MOD, 768, 1024, 0, 0), 1, make_rsp(1280, 0, 0, 0));
    add_row(make_req(cau_pkg::ACT_MOD, -32768, -32768, 0, 0), 1,
            make_rsp(32767, 0, 0, 1));
    add_row(make_req(cau_pkg::ACT_MOD, 1, 1, 0, 0), 0, none);
    add_row(make_req(cau_pkg::ACT_INV, 0, 0, 5, 5), 1, make_rsp(0, 0, 1, 0));
    add_row(make_req(cau_pkg::ACT_INV, 256, 0, 0, 0), 1, make_rsp(256, 0, 0, 0));
    add_row(make_req(cau_pkg::ACT_INV, 1, 0, 0, 0), 1, make_rsp(32767, 0, 0, 1));
    add_row(make_req(cau_pkg::ACT_INV, 0, -1, 0, 0), 1, make_rsp(0, 32767, 0, 1));
    add_row(make_req(cau_pkg::ACT_INV, -32768, -32768, 0, 0), 0, none);
    add_row(make_req(cau_pkg::ACT_INV, 3, 7, 0, 0), 0, none);
    add_row(make_req(3'd5, 32767, 32767, 32767, 32767), 1, make_rsp(0, 0, 0, 0));
    add_row(make_req(3'd6, -1, -1, -1, -1), 1, make_rsp(0, 0, 0, 0));
    add_row(make_req(3'd7, 1, 2, 3, 4), 1, make_rsp(0, 0, 0, 0));

    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (vectors[i]) begin
      // A typed-in result must agree with the prediction as well.
      if (vectors[i].has_known &&
          complex_result(vectors[i].req) !== vectors[i].known) begin
        mismatches++;
        if (mismatches <= 10)
          $display("directed row %0d: prediction disagrees with table", i);
      end
      send_req(vectors[i].req);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - 150) quiet_tail = 1;
      send_req(random_req());
    end
    req_valid <= 0;
    stimulus_done = 1;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);

    $display("covered %0d transactions (%0d directed), %0d responses checked",
             sent, vectors.size(), received);
    if (mismatches == 0) begin
      $display("complex_arithmetic_unit_tb passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("complex_arithmetic_unit_tb failed");
    end
    $finish;
  end

endmodule
